// ----- rtl/core/hpbp_pkg.sv -----
// shared types and constants for the hpack header block parser
package hpbp_pkg;

	localparam int STATIC_TABLE_ENTRIES = 61;

	localparam int FQ_DEPTH = 4;
	localparam int FQ_AW    = $clog2(FQ_DEPTH);
	localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);

	localparam int OQ_DEPTH = 2;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);
	localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

	typedef enum logic [2:0] {
		EV_INDEXED   = 3'd0,
		EV_LIT_START = 3'd1,
		EV_STR_LEN   = 3'd2,
		EV_STR_BYTE  = 3'd3,
		EV_SIZE_UPD  = 3'd4,
		EV_ERROR     = 3'd5
	} ev_kind_t;

	typedef enum logic [1:0] {
		ERR_NONE       = 2'd0,
		ERR_ZERO_INDEX = 2'd1,
		ERR_OVERFLOW   = 2'd2,
		ERR_TRUNCATED  = 2'd3
	} err_code_t;

	typedef enum logic [1:0] {
		REP_INDEXED   = 2'd0,
		REP_INC_INDEX = 2'd1,
		REP_SIZE_UPD  = 2'd2,
		REP_NO_INDEX  = 2'd3
	} rep_kind_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		rep_kind_t  rep;
		logic [6:0] prefix;
		logic       prefix_max;
		logic [6:0] len7;
		logic       len_max;
	} item_t;

	typedef struct packed {
		ev_kind_t   kind;
		logic [31:0] number;
		logic       is_value_string;
		logic       huffman_coded;
		logic       add_to_table;
		logic       static_entry;
		logic [7:0] data_byte;
		logic       last_of_string;
		logic       end_of_block_seen;
		err_code_t  error_code;
	} event_t;

endpackage

// ----- rtl/core/hpbp_front.sv -----
// byte intake: prefix classification and byte queue
module hpbp_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  logic [7:0]      in_byte,
	input  logic            block_end,
	output logic            full,
	output logic            item_valid,
	output hpbp_pkg::item_t item,
	input  logic            item_take
);
	import hpbp_pkg::*;

	item_t             cls;
	item_t             mem_q [FQ_DEPTH];
	logic [FQ_AW-1:0]  wr_ptr_q;
	logic [FQ_AW-1:0]  rd_ptr_q;
	logic [FQ_CW-1:0]  cnt_q;
	logic              push_ok;
	logic              pop_ok;

	always_comb begin
		cls            = '0;
		cls.data       = in_byte;
		cls.last       = block_end;
		cls.len7       = in_byte[6:0];
		cls.len_max    = &in_byte[6:0];
		if (in_byte[7]) begin
			cls.rep        = REP_INDEXED;
			cls.prefix     = in_byte[6:0];
			cls.prefix_max = &in_byte[6:0];
		end else if (in_byte[6]) begin
			cls.rep        = REP_INC_INDEX;
			cls.prefix     = {1'b0, in_byte[5:0]};
			cls.prefix_max = &in_byte[5:0];
		end else if (in_byte[5]) begin
			cls.rep        = REP_SIZE_UPD;
			cls.prefix     = {2'b0, in_byte[4:0]};
			cls.prefix_max = &in_byte[4:0];
		end else begin
			cls.rep        = REP_NO_INDEX;
			cls.prefix     = {3'b0, in_byte[3:0]};
			cls.prefix_max = &in_byte[3:0];
		end
	end

	assign full       = (cnt_q == FQ_CW'(FQ_DEPTH));
	assign item_valid = (cnt_q != '0);
	assign item       = mem_q[rd_ptr_q];
	assign push_ok    = push && !full;
	assign pop_ok     = item_take && item_valid;

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push_ok, pop_ok})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- rtl/core/hpbp_back.sv -----
// representation parser and event queue
module hpbp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  hpbp_pkg::item_t  item,
	output logic             item_take,
	output hpbp_pkg::event_t ev_out,
	output logic             empty,
	input  logic             pop
);
	import hpbp_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_REP_INT,
		PH_LEN_FIRST,
		PH_LEN_INT,
		PH_STRING,
		PH_SKIP
	} phase_t;

	phase_t            phase_q,  ph_d;
	rep_kind_t         rep_q,    rep_d;
	logic [32:0]       acc_q,    acc_d;
	logic [2:0]        cont_q,   cont_d;
	logic [31:0]       rem_q,    rem_d;
	logic              value_q,  value_d;
	logic              huff_q,   huff_d;

	event_t            ev_d;
	logic              have;
	logic              err;
	err_code_t         code;
	logic              do_rep;
	logic              do_len;
	logic              str_done;
	logic              int_done;
	logic              over;
	logic [31:0]       fin_v;
	logic [32:0]       shifted;
	logic [32:0]       acc_sum;
	logic [31:0]       rem_dec;
	logic              fin_static;

	event_t            oq_mem_q [OQ_DEPTH];
	logic [OQ_AW-1:0]  oq_wr_q;
	logic [OQ_AW-1:0]  oq_rd_q;
	logic [OQ_CW-1:0]  oq_cnt_q;
	logic              oq_full;
	logic              ev_push;
	logic              ev_pop;

	assign oq_full   = (oq_cnt_q == OQ_CW'(OQ_DEPTH));
	assign item_take = item_valid && !oq_full;

	// continuation byte arithmetic
	always_comb begin
		case (cont_q[1:0])
			2'd0:    shifted = {26'b0, item.data[6:0]};
			2'd1:    shifted = {19'b0, item.data[6:0], 7'b0};
			2'd2:    shifted = {12'b0, item.data[6:0], 14'b0};
			default: shifted = {5'b0, item.data[6:0], 21'b0};
		endcase
		if (cont_q >= 3'd4) begin
			acc_sum = acc_q + {1'b0, item.data[3:0], 28'b0};
		end else begin
			acc_sum = acc_q + shifted;
		end
	end

	assign rem_dec    = rem_q - {31'b0, (rem_q != '0)};
	assign fin_static = (fin_v != '0) && (fin_v <= 32'(STATIC_TABLE_ENTRIES));

	always_comb begin
		ph_d     = phase_q;
		rep_d    = rep_q;
		acc_d    = acc_q;
		cont_d   = cont_q;
		rem_d    = rem_q;
		value_d  = value_q;
		huff_d   = huff_q;
		ev_d     = '0;
		have     = 1'b0;
		err      = 1'b0;
		code     = ERR_NONE;
		do_rep   = 1'b0;
		do_len   = 1'b0;
		str_done = 1'b0;
		int_done = 1'b0;
		over     = 1'b0;
		fin_v    = '0;

		case (phase_q)
			PH_IDLE: begin
				rep_d   = item.rep;
				value_d = 1'b0;
				if (!item.prefix_max) begin
					if (item.rep == REP_INDEXED && item.prefix == '0) begin
						err  = 1'b1;
						code = ERR_ZERO_INDEX;
					end else begin
						do_rep = 1'b1;
						fin_v  = {25'b0, item.prefix};
					end
				end else begin
					acc_d  = {26'b0, item.prefix};
					cont_d = '0;
					ph_d   = PH_REP_INT;
				end
			end
			PH_REP_INT, PH_LEN_INT: begin
				if (cont_q >= 3'd4) begin
					if (item.data > 8'h0F) begin
						over = 1'b1;
					end else begin
						acc_d    = acc_sum;
						int_done = 1'b1;
					end
				end else begin
					acc_d = acc_sum;
					if (item.data[7]) begin
						cont_d = cont_q + 3'd1;
					end else begin
						int_done = 1'b1;
					end
				end
				if (int_done && acc_sum[32]) begin
					over     = 1'b1;
					int_done = 1'b0;
				end
				if (over) begin
					err  = 1'b1;
					code = ERR_OVERFLOW;
				end else if (int_done) begin
					fin_v = acc_sum[31:0];
					if (phase_q == PH_REP_INT) begin
						do_rep = 1'b1;
					end else begin
						do_len = 1'b1;
					end
				end
			end
			PH_LEN_FIRST: begin
				huff_d = item.data[7];
				if (!item.len_max) begin
					do_len = 1'b1;
					fin_v  = {25'b0, item.len7};
				end else begin
					acc_d  = 33'h7F;
					cont_d = '0;
					ph_d   = PH_LEN_INT;
				end
			end
			PH_STRING: begin
				rem_d                = rem_dec;
				ev_d.kind            = EV_STR_BYTE;
				ev_d.is_value_string = value_q;
				ev_d.huffman_coded   = huff_q;
				ev_d.data_byte       = item.data;
				ev_d.last_of_string  = (rem_dec == '0);
				have                 = 1'b1;
				str_done             = (rem_dec == '0);
			end
			default: begin
				have = 1'b0;
			end
		endcase

		if (do_rep) begin
			have        = 1'b1;
			ev_d.number = fin_v;
			case (rep_d)
				REP_INDEXED: begin
					ev_d.kind         = EV_INDEXED;
					ev_d.static_entry = fin_static;
					ph_d              = PH_IDLE;
				end
				REP_SIZE_UPD: begin
					ev_d.kind = EV_SIZE_UPD;
					ph_d      = PH_IDLE;
				end
				default: begin
					ev_d.kind         = EV_LIT_START;
					ev_d.static_entry = fin_static;
					ev_d.add_to_table = (rep_d == REP_INC_INDEX);
					value_d           = (fin_v != '0);
					ph_d              = PH_LEN_FIRST;
				end
			endcase
		end

		if (do_len) begin
			have                 = 1'b1;
			ev_d.kind            = EV_STR_LEN;
			ev_d.number          = fin_v;
			ev_d.is_value_string = value_d;
			ev_d.huffman_coded   = huff_d;
			ev_d.last_of_string  = (fin_v == '0);
			if (fin_v == '0) begin
				str_done = 1'b1;
			end else begin
				rem_d = fin_v;
				ph_d  = PH_STRING;
			end
		end

		if (str_done) begin
			if (!value_d) begin
				value_d = 1'b1;
				ph_d    = PH_LEN_FIRST;
			end else begin
				value_d = 1'b0;
				ph_d    = PH_IDLE;
			end
		end

		if (err) begin
			ev_d            = '0;
			ev_d.kind       = EV_ERROR;
			ev_d.error_code = code;
			have            = 1'b1;
			ph_d            = PH_SKIP;
		end

		if (item.last) begin
			if (!err && ph_d != PH_IDLE && ph_d != PH_SKIP) begin
				ev_d            = '0;
				ev_d.kind       = EV_ERROR;
				ev_d.error_code = ERR_TRUNCATED;
				have            = 1'b1;
			end
			ev_d.end_of_block_seen = 1'b1;
			ph_d    = PH_IDLE;
			value_d = 1'b0;
			cont_d  = '0;
			acc_d   = '0;
			rem_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			rep_q   <= REP_INDEXED;
			acc_q   <= '0;
			cont_q  <= '0;
			rem_q   <= '0;
			value_q <= 1'b0;
			huff_q  <= 1'b0;
		end else if (item_take) begin
			phase_q <= ph_d;
			rep_q   <= rep_d;
			acc_q   <= acc_d;
			cont_q  <= cont_d;
			rem_q   <= rem_d;
			value_q <= value_d;
			huff_q  <= huff_d;
		end
	end

	// event queue
	assign ev_push = item_take && have;
	assign ev_pop  = pop && !empty;
	assign empty   = (oq_cnt_q == '0);
	assign ev_out  = oq_mem_q[oq_rd_q];

	always_ff @(posedge clk) begin
		if (ev_push) begin
			oq_mem_q[oq_wr_q] <= ev_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (ev_push) begin
				oq_wr_q <= oq_wr_q + 1'b1;
			end
			if (ev_pop) begin
				oq_rd_q <= oq_rd_q + 1'b1;
			end
			case ({ev_push, ev_pop})
				2'b10:   oq_cnt_q <= oq_cnt_q + 1'b1;
				2'b01:   oq_cnt_q <= oq_cnt_q - 1'b1;
				default: oq_cnt_q <= oq_cnt_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_oq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		oq_cnt_q <= OQ_CW'(OQ_DEPTH))
		else $error("event queue count out of range");

	a_str_rem: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_STRING |-> rem_q != '0)
		else $error("string phase with no bytes remaining");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		ev_push && ev_d.kind == EV_ERROR |-> ev_d.error_code != ERR_NONE)
		else $error("error event without code");

	a_skip_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_take && phase_q == PH_SKIP && !item.last |=> phase_q == PH_SKIP)
		else $error("left skip before block end");

	a_eob_idle: assert property (@(posedge clk) disable iff (!arst_n)
		item_take && item.last |=> phase_q == PH_IDLE)
		else $error("parser not idle after block end");
`endif

endmodule

// ----- rtl/core/hpack_header_block_parser.sv -----
// hpack header block parser top level
// accepted bytes wait in the byte queue, and their events in the event queue
// throughput: one byte per cycle while the event queue is not full
// a 4-entry byte queue and a 2-entry event queue decouple intake from delivery
// arst_n low clears both queues and returns the parser to idle
module hpack_header_block_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  in_byte,
	input  logic        block_end,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  event_kind,
	output logic [31:0] number,
	output logic        is_value_string,
	output logic        huffman_coded,
	output logic        add_to_table,
	output logic        static_entry,
	output logic [7:0]  data_byte,
	output logic        last_of_string,
	output logic        end_of_block_seen,
	output logic [1:0]  error_code
);
	import hpbp_pkg::*;

	item_t  item;
	logic   item_valid;
	logic   item_take;
	event_t ev;

	hpbp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.in_byte    (in_byte),
		.block_end  (block_end),
		.full       (full),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take)
	);

	hpbp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take),
		.ev_out     (ev),
		.empty      (empty),
		.pop        (pop)
	);

	assign event_kind        = ev.kind;
	assign number            = ev.number;
	assign is_value_string   = ev.is_value_string;
	assign huffman_coded     = ev.huffman_coded;
	assign add_to_table      = ev.add_to_table;
	assign static_entry      = ev.static_entry;
	assign data_byte         = ev.data_byte;
	assign last_of_string    = ev.last_of_string;
	assign end_of_block_seen = ev.end_of_block_seen;
	assign error_code        = ev.error_code;

endmodule
